FILE: src/rsi_pkg.sv
// shared constant and helper function for the ray-sphere intersection pipeline
package rsi_pkg;

    // operand slice width of the partial-product multipliers
    localparam int MUL_CHUNK = 32;

    function automatic int imax(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

endpackage

FILE: src/rsi_mul.sv
// pipelined signed multiplier built from 32x32 partial products, five register stages
module rsi_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SW = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    src_valid,
    input  logic signed [AW-1:0]    src_a,
    input  logic signed [BW-1:0]    src_b,
    input  logic [SW-1:0]           src_side,
    output logic                    res_valid,
    output logic signed [AW+BW-1:0] res_prod,
    output logic [SW-1:0]           res_side
);

    localparam int C  = rsi_pkg::MUL_CHUNK;
    localparam int NA = (AW + C - 1) / C;
    localparam int NB = (BW + C - 1) / C;
    localparam int MA = NA * C;
    localparam int MB = NB * C;
    localparam int RW = C * (NB + 1);
    localparam int TW = C * (NA + NB);
    localparam int PW = AW + BW;

    logic [AW-1:0]   abs_a;
    logic [BW-1:0]   abs_b;
    logic [MA-1:0]   ma_reg;
    logic [MB-1:0]   mb_reg;
    logic [2*C-1:0]  pp_next [0:NA-1][0:NB-1];
    logic [2*C-1:0]  pp_reg  [0:NA-1][0:NB-1];
    logic [RW-1:0]   row_next [0:NA-1];
    logic [RW-1:0]   row_reg  [0:NA-1];
    logic [TW-1:0]   tot_next;
    logic [TW-1:0]   tot_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_reg;
    logic [3:0]      neg_reg;
    logic [4:0]      valid_reg;
    logic [SW-1:0]   side_reg [0:4];

    assign abs_a = src_a[AW-1] ? AW'(-src_a) : AW'(src_a);
    assign abs_b = src_b[BW-1] ? BW'(-src_b) : BW'(src_b);

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_next[i][j] = (2*C)'(ma_reg[i*C +: C]) * (2*C)'(mb_reg[j*C +: C]);
            end
        end
    end

    always_comb
    begin
        logic [RW-1:0] acc;
        for (int i = 0; i < NA; i++)
        begin
            acc = '0;
            for (int j = 0; j < NB; j++)
            begin
                acc = acc + (RW'(pp_reg[i][j]) << (C * j));
            end
            row_next[i] = acc;
        end
    end

    always_comb
    begin
        logic [TW-1:0] acc;
        acc = '0;
        for (int i = 0; i < NA; i++)
        begin
            acc = acc + (TW'(row_reg[i]) << (C * i));
        end
        tot_next = acc;
    end

    assign prod_next = neg_reg[3] ? -$signed(tot_reg[PW-1:0]) : $signed(tot_reg[PW-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], src_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg     <= MA'(abs_a);
            mb_reg     <= MB'(abs_b);
            neg_reg    <= {neg_reg[2:0], src_a[AW-1] ^ src_b[BW-1]};
            side_reg[0] <= src_side;
            for (int k = 1; k < 5; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            pp_reg   <= pp_next;
            row_reg  <= row_next;
            tot_reg  <= tot_next;
            prod_reg <= prod_next;
        end
    end

    assign res_valid = valid_reg[4];
    assign res_prod  = prod_reg;
    assign res_side  = side_reg[4];

endmodule

FILE: src/rsi_sqrt.sv
// pipelined restoring integer square root, one result bit per register stage
module rsi_sqrt #(
    parameter int IW = 134,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            src_valid,
    input  logic [IW-1:0]   src_radicand,
    input  logic [SW-1:0]   src_side,
    output logic            res_valid,
    output logic [IW/2-1:0] res_root,
    output logic [SW-1:0]   res_side
);

    localparam int OW  = IW / 2;
    localparam int RMW = OW + 2;

    logic [RMW-1:0] rem_reg  [0:OW-1];
    logic [OW-1:0]  root_reg [0:OW-1];
    logic [IW-1:0]  tsh_reg  [0:OW-1];
    logic [SW-1:0]  side_reg [0:OW-1];
    logic [OW-1:0]  valid_reg;

    for (genvar k = 0; k < OW; k++)
    begin : g_stage
        logic [RMW-1:0] rem_p;
        logic [OW-1:0]  root_p;
        logic [IW-1:0]  tsh_p;
        logic [SW-1:0]  side_p;
        logic           valid_p;
        logic [RMW+1:0] cur;
        logic [RMW+1:0] trial;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign rem_p   = '0;
            assign root_p  = '0;
            assign tsh_p   = src_radicand;
            assign side_p  = src_side;
            assign valid_p = src_valid;
        end
        else
        begin : g_next
            assign rem_p   = rem_reg[k-1];
            assign root_p  = root_reg[k-1];
            assign tsh_p   = tsh_reg[k-1];
            assign side_p  = side_reg[k-1];
            assign valid_p = valid_reg[k-1];
        end

        assign cur   = {rem_p, tsh_p[IW-1 -: 2]};
        assign trial = (RMW+2)'({root_p, 2'b01});
        assign ge    = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? RMW'(cur - trial) : RMW'(cur);
                root_reg[k] <= {root_p[OW-2:0], ge};
                tsh_reg[k]  <= tsh_p << 2;
                side_reg[k] <= side_p;
            end
        end
    end

    assign res_valid = valid_reg[OW-1];
    assign res_root  = root_reg[OW-1];
    assign res_side  = side_reg[OW-1];

endmodule

FILE: src/rsi_div.sv
// pipelined restoring divider, one quotient bit per register stage
module rsi_div #(
    parameter int NW = 98,
    parameter int DW = 66,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          src_valid,
    input  logic [NW-1:0] src_num,
    input  logic [DW-1:0] src_den,
    input  logic [SW-1:0] src_side,
    output logic          res_valid,
    output logic [QW-1:0] res_quot,
    output logic [SW-1:0] res_side
);

    logic [NW-1:0] rem_reg  [0:QW-1];
    logic [DW-1:0] den_reg  [0:QW-1];
    logic [QW-1:0] q_reg    [0:QW-1];
    logic [SW-1:0] side_reg [0:QW-1];
    logic [QW-1:0] valid_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [NW-1:0] rem_p;
        logic [DW-1:0] den_p;
        logic [QW-1:0] q_p;
        logic [SW-1:0] side_p;
        logic          valid_p;
        logic [NW-1:0] trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_p   = src_num;
            assign den_p   = src_den;
            assign q_p     = '0;
            assign side_p  = src_side;
            assign valid_p = src_valid;
        end
        else
        begin : g_next
            assign rem_p   = rem_reg[k-1];
            assign den_p   = den_reg[k-1];
            assign q_p     = q_reg[k-1];
            assign side_p  = side_reg[k-1];
            assign valid_p = valid_reg[k-1];
        end

        assign trial = NW'(den_p) << (QW - 1 - k);
        assign ge    = (rem_p >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (rem_p - trial) : rem_p;
                den_reg[k]  <= den_p;
                q_reg[k]    <= {q_p[QW-2:0], ge};
                side_reg[k] <= side_p;
            end
        end
    end

    assign res_valid = valid_reg[QW-1];
    assign res_quot  = q_reg[QW-1];
    assign res_side  = side_reg[QW-1];

endmodule

FILE: src/ray_sphere_intersect.sv
// top level of the ray-sphere intersection pipeline
//
// Takes one ray and one sphere per transfer and returns one result per transfer, in order.
// The datapath is a fixed pipeline that accepts a new item every cycle while in_stall is low;
// its depth is set by the square root (one stage per root bit, 2*COORD_WIDTH+3) and the
// divider (one stage per quotient bit, COORD_WIDTH) plus two five-stage multiplier banks.
// All arithmetic is exact; a discriminant at or below zero or a zero direction gives hit=0
// and hit_fraction=0, and the fraction saturates to the signed range. A one-entry skid buffer
// behind the output register lets the pipeline keep moving while a result waits; in_stall
// rises only when that buffer is occupied.
module ray_sphere_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] dir_z,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic [COORD_WIDTH-2:0]        sphere_radius,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] hit_fraction
);

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int E  = 2 * W + 3;
    localparam int AW = 2 * W + 2;
    localparam int TW = 2 * E;
    localparam int OW = TW / 2;
    localparam int PW = OW + 2;
    localparam int NW = PW + F;
    localparam int XW = rsi_pkg::imax(NW, AW + W);
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

    logic en;

    // input stage
    logic signed [W-1:0] o_w [0:2];
    logic signed [W-1:0] d_w [0:2];
    logic signed [W-1:0] c_w [0:2];
    logic signed [W-1:0] d0_reg [0:2];
    logic signed [W:0]   s0_reg [0:2];
    logic signed [W-1:0] rad0_reg;
    logic                v0_reg;

    assign o_w[0] = origin_x;
    assign o_w[1] = origin_y;
    assign o_w[2] = origin_z;
    assign d_w[0] = dir_x;
    assign d_w[1] = dir_y;
    assign d_w[2] = dir_z;
    assign c_w[0] = center_x;
    assign c_w[1] = center_y;
    assign c_w[2] = center_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d0_reg[i] <= d_w[i];
                s0_reg[i] <= (W+1)'(o_w[i]) - (W+1)'(c_w[i]);
            end
            rad0_reg <= $signed({1'b0, sphere_radius});
        end
    end

    // first multiplier bank
    logic signed [2*W-1:0] dd_w [0:2];
    logic signed [2*W:0]   ds_w [0:2];
    logic signed [2*W+1:0] ss_w [0:2];
    logic signed [2*W-1:0] rr_w;
    logic                  m1_valid;

    for (genvar i = 0; i < 3; i++)
    begin : g_mul1
        rsi_mul #(.AW(W), .BW(W), .SW(1)) u_dd (
            .clk(clk), .rst_n(rst_n), .en(en),
            .src_valid(1'b0), .src_a(d0_reg[i]), .src_b(d0_reg[i]), .src_side(1'b0),
            .res_valid(), .res_prod(dd_w[i]), .res_side()
        );
        rsi_mul #(.AW(W), .BW(W+1), .SW(1)) u_ds (
            .clk(clk), .rst_n(rst_n), .en(en),
            .src_valid(1'b0), .src_a(d0_reg[i]), .src_b(s0_reg[i]), .src_side(1'b0),
            .res_valid(), .res_prod(ds_w[i]), .res_side()
        );
        rsi_mul #(.AW(W+1), .BW(W+1), .SW(1)) u_ss (
            .clk(clk), .rst_n(rst_n), .en(en),
            .src_valid(1'b0), .src_a(s0_reg[i]), .src_b(s0_reg[i]), .src_side(1'b0),
            .res_valid(), .res_prod(ss_w[i]), .res_side()
        );
    end

    rsi_mul #(.AW(W), .BW(W), .SW(1)) u_rr (
        .clk(clk), .rst_n(rst_n), .en(en),
        .src_valid(v0_reg), .src_a(rad0_reg), .src_b(rad0_reg), .src_side(1'b0),
        .res_valid(m1_valid), .res_prod(rr_w), .res_side()
    );

    // a, b, c sums
    logic signed [E-1:0] a_sum;
    logic [AW-1:0]       a1_reg;
    logic signed [E-1:0] b1_reg;
    logic signed [E-1:0] c1_reg;
    logic                v1_reg;

    assign a_sum = E'(dd_w[0]) + E'(dd_w[1]) + E'(dd_w[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= a_sum[AW-1:0];
            b1_reg <= E'(ds_w[0]) + E'(ds_w[1]) + E'(ds_w[2]);
            c1_reg <= E'(ss_w[0]) + E'(ss_w[1]) + E'(ss_w[2]) - E'(rr_w);
        end
    end

    // second multiplier bank
    logic signed [TW-1:0] bb_w;
    logic signed [TW-1:0] ac_w;
    logic [AW+E-1:0]      m2_side;
    logic                 m2_valid;

    rsi_mul #(.AW(E), .BW(E), .SW(AW+E)) u_bb (
        .clk(clk), .rst_n(rst_n), .en(en),
        .src_valid(v1_reg), .src_a(b1_reg), .src_b(b1_reg), .src_side({a1_reg, b1_reg}),
        .res_valid(m2_valid), .res_prod(bb_w), .res_side(m2_side)
    );

    rsi_mul #(.AW(E), .BW(E), .SW(1)) u_ac (
        .clk(clk), .rst_n(rst_n), .en(en),
        .src_valid(1'b0), .src_a($signed({1'b0, a1_reg})), .src_b(c1_reg), .src_side(1'b0),
        .res_valid(), .res_prod(ac_w), .res_side()
    );

    // discriminant
    logic signed [TW-1:0] t_w;
    logic                 miss_w;
    logic [TW-1:0]        t2_reg;
    logic [AW+E:0]        side2_reg;
    logic                 v2_reg;

    assign t_w    = bb_w - ac_w;
    assign miss_w = (m2_side[AW+E-1:E] == '0) || t_w[TW-1] || (t_w == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_reg    <= miss_w ? '0 : t_w;
            side2_reg <= {m2_side, miss_w};
        end
    end

    // square root
    logic [OW-1:0]   root_w;
    logic [AW+E:0]   sq_side;
    logic            sq_valid;

    rsi_sqrt #(.IW(TW), .SW(AW+E+1)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .src_valid(v2_reg), .src_radicand(t2_reg), .src_side(side2_reg),
        .res_valid(sq_valid), .res_root(root_w), .res_side(sq_side)
    );

    // numerator and sign
    logic signed [E-1:0]  b3_w;
    logic signed [PW-1:0] p_w;
    logic [PW-1:0]        mag_w;
    logic [XW-1:0]        num3_reg;
    logic [AW-1:0]        a3_reg;
    logic                 neg3_reg;
    logic                 miss3_reg;
    logic                 v3_reg;

    assign b3_w  = sq_side[E:1];
    assign p_w   = PW'(b3_w) + $signed({2'b00, root_w});
    assign mag_w = p_w[PW-1] ? PW'(-p_w) : PW'(p_w);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num3_reg  <= XW'({mag_w, {F{1'b0}}});
            a3_reg    <= sq_side[AW+E:E+1];
            neg3_reg  <= !p_w[PW-1] && (p_w != '0);
            miss3_reg <= sq_side[0];
        end
    end

    // quotient overflow check
    logic [XW-1:0] num4_reg;
    logic [AW-1:0] a4_reg;
    logic [2:0]    side4_reg;
    logic          v4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num4_reg  <= num3_reg;
            a4_reg    <= a3_reg;
            side4_reg <= {neg3_reg, miss3_reg, num3_reg >= XW'({a3_reg, {W{1'b0}}})};
        end
    end

    // division
    logic [W-1:0] q_w;
    logic [2:0]   dv_side;
    logic         dv_valid;

    rsi_div #(.NW(XW), .DW(AW), .QW(W), .SW(3)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .src_valid(v4_reg), .src_num(num4_reg), .src_den(a4_reg), .src_side(side4_reg),
        .res_valid(dv_valid), .res_quot(q_w), .res_side(dv_side)
    );

    // saturation and result
    logic [W-1:0] frac_w;
    logic         hit5_reg;
    logic [W-1:0] frac5_reg;
    logic         v5_reg;

    always_comb
    begin
        if (dv_side[1])
        begin
            frac_w = '0;
        end
        else if (dv_side[2])
        begin
            frac_w = (dv_side[0] || (q_w > MIN_NEG)) ? MIN_NEG : W'(-q_w);
        end
        else
        begin
            frac_w = (dv_side[0] || (q_w > MAX_POS)) ? MAX_POS : q_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit5_reg  <= !dv_side[1];
            frac5_reg <= frac_w;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= m1_valid;
            v2_reg <= m2_valid;
            v3_reg <= sq_valid;
            v4_reg <= v3_reg;
            v5_reg <= dv_valid;
        end
    end

    // output register and skid buffer
    logic         out_valid_reg;
    logic         hit_reg;
    logic [W-1:0] frac_reg;
    logic         skid_valid_reg;
    logic         skid_hit_reg;
    logic [W-1:0] skid_frac_reg;
    logic         push;
    logic         out_free;

    assign en       = !skid_valid_reg;
    assign push     = en && v5_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                hit_reg  <= skid_hit_reg;
                frac_reg <= skid_frac_reg;
            end
            else if (push)
            begin
                hit_reg  <= hit5_reg;
                frac_reg <= frac5_reg;
            end
        end
        else if (push)
        begin
            skid_hit_reg  <= hit5_reg;
            skid_frac_reg <= frac5_reg;
        end
    end

    assign in_stall     = skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign hit_fraction = frac_reg;

endmodule
